@@ sv/integer_pixel_replicating_upscaler_top_assert.svh @@
// assertion macros used by the upscaler checker
`ifndef INTEGER_PIXEL_REPLICATING_UPSCALER_TOP_ASSERT_SVH
`define INTEGER_PIXEL_REPLICATING_UPSCALER_TOP_ASSERT_SVH

// clocked check, quiet while reset is asserted
`define IPRU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also covers reset cycles
`define IPRU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ipru_pkg.sv @@
// shared types, constants and register codes of the pixel upscaler
package ipru_pkg;

  localparam int PIXEL_BITS      = 32;
  localparam int MAX_ROW_WIDTH   = 1024;
  localparam int MAX_SCALE       = 16;
  localparam int MAX_RECT_HEIGHT = 1024;

  localparam int SCALE_W = 5;
  localparam int SIZE_W  = 11;
  localparam int CFG_W   = 11;
  localparam int ADDR_W  = 2;
  localparam int COL_W   = $clog2(MAX_ROW_WIDTH);
  localparam int ROW_W   = $clog2(MAX_RECT_HEIGHT);
  localparam int PASS_W  = $clog2(MAX_SCALE);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] PIXEL_MASK = (PIXEL_BITS >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << PIXEL_BITS) - 64'd1);

  // register indexes
  localparam logic [ADDR_W-1:0] REG_SCALE_X     = 2'd0;
  localparam logic [ADDR_W-1:0] REG_SCALE_Y     = 2'd1;
  localparam logic [ADDR_W-1:0] REG_ROW_WIDTH   = 2'd2;
  localparam logic [ADDR_W-1:0] REG_RECT_HEIGHT = 2'd3;

  // input item kinds
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_REPLAY = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] pixel;
  } ipru_in_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        last_of_run;
    logic        end_of_line;
    logic        end_of_rect;
    logic        rejected;
  } ipru_out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [31:0] value;
    logic        eol;
    logic        eor;
    logic        rejected;
  } ipru_entry_t;

  // clamped configuration
  typedef struct packed {
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [SIZE_W-1:0]  row_width;
    logic [SIZE_W-1:0]  rect_height;
  } ipru_cfg_t;

endpackage

@@ sv/ipru_front.sv @@
// front end: accepts items, checks their kind, tracks position, owns the line store
module ipru_front import ipru_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ipru_cfg_t   cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  ipru_in_t    in_data,
  output logic        q_push,
  input  logic        q_ready,
  output ipru_entry_t q_entry
);

  logic [31:0] line_store [MAX_ROW_WIDTH];
  logic [31:0] rd_data_r;

  logic [COL_W-1:0]  col_r,  col_nxt;
  logic [ROW_W-1:0]  row_r,  row_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;

  logic        s1_v_r, s1_v_nxt;
  logic        s1_replay_r;
  logic        s1_rej_r;
  logic        s1_eol_r;
  logic        s1_eor_r;
  logic [31:0] s1_pix_r;

  logic accept, is_replay, bad, good;
  logic col_last, pass_last, row_last;
  logic eol, eor;

  // classification and end-of-line / pass / rectangle tests
  always_comb begin
    accept    = in_valid && in_ready;
    is_replay = (in_data.cmd == CMD_REPLAY);
    bad       = is_replay != (pass_r != '0);
    good      = accept && !bad;
    col_last  = (SIZE_W'(col_r) + SIZE_W'(1)) >= cfg.row_width;
    pass_last = (SCALE_W'(pass_r) + SCALE_W'(1)) >= cfg.scale_y;
    row_last  = (SIZE_W'(row_r) + SIZE_W'(1)) >= cfg.rect_height;
    eol       = col_last;
    eor       = col_last && pass_last && row_last;
  end

  // position counters
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    pass_nxt = pass_r;
    if (good) begin
      if (col_last) begin
        col_nxt = '0;
        if (pass_last) begin
          pass_nxt = '0;
          row_nxt  = row_last ? '0 : row_r + ROW_W'(1);
        end else begin
          pass_nxt = pass_r + PASS_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pass_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pass_r <= pass_nxt;
    end
  end

  // line store: write on loads, registered read on replays
  always_ff @(posedge clk) begin
    if (good && !is_replay) begin
      line_store[col_r] <= in_data.pixel & PIXEL_MASK;
    end
    if (good && is_replay) begin
      rd_data_r <= line_store[col_r];
    end
  end

  // stage holding the classified item until the queue takes it
  assign q_push   = s1_v_r && q_ready;
  assign in_ready = !s1_v_r || q_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (q_push) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_replay_r <= is_replay;
      s1_rej_r    <= bad;
      s1_eol_r    <= eol && !bad;
      s1_eor_r    <= eor && !bad;
      s1_pix_r    <= in_data.pixel & PIXEL_MASK;
    end
  end

  // entry toward the back end
  always_comb begin
    q_entry.rejected = s1_rej_r;
    q_entry.eol      = s1_eol_r;
    q_entry.eor      = s1_eor_r;
    if (s1_rej_r) begin
      q_entry.value = '0;
    end else if (s1_replay_r) begin
      q_entry.value = rd_data_r;
    end else begin
      q_entry.value = s1_pix_r;
    end
  end

endmodule

@@ sv/ipru_queue.sv @@
// small fifo of classified items between front and back
module ipru_queue import ipru_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        push_ready,
  input  ipru_entry_t push_entry,
  input  logic        pop,
  output logic        pop_valid,
  output ipru_entry_t pop_entry
);

  ipru_entry_t slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r,  count_nxt;

  assign push_ready = count_r != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_entry  = slots[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ sv/ipru_back.sv @@
// back end: scale_x copies per item, one if rejected, via the output register
module ipru_back import ipru_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ipru_cfg_t   cfg,
  input  logic        q_valid,
  input  ipru_entry_t q_entry,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output ipru_out_t   out_data
);

  ipru_entry_t        cur_r;
  logic               cur_v_r, cur_v_nxt;
  logic [SCALE_W-1:0] cnt_r, cnt_nxt;
  logic               out_v_r, out_v_nxt;
  ipru_out_t          out_r;

  logic copy_last, out_load;

  always_comb begin
    copy_last = cur_r.rejected || ((cnt_r + SCALE_W'(1)) == cfg.scale_x);
    out_load  = cur_v_r && (!out_v_r || out_ready);
    q_pop     = q_valid && (!cur_v_r || (out_load && copy_last));
  end

  // current item and copy counter
  always_comb begin
    cur_v_nxt = cur_v_r;
    cnt_nxt   = cnt_r;
    if (q_pop) begin
      cur_v_nxt = 1'b1;
      cnt_nxt   = '0;
    end else if (out_load && copy_last) begin
      cur_v_nxt = 1'b0;
    end else if (out_load) begin
      cnt_nxt = cnt_r + SCALE_W'(1);
    end
  end

  // output register
  always_comb begin
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      cnt_r   <= cnt_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_entry;
    end
    if (out_load) begin
      out_r.pixel_out   <= cur_r.value;
      out_r.last_of_run <= copy_last;
      out_r.end_of_line <= copy_last && cur_r.eol;
      out_r.end_of_rect <= copy_last && cur_r.eor;
      out_r.rejected    <= cur_r.rejected;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

@@ sv/integer_pixel_replicating_upscaler_top.sv @@
// top level of the nearest-neighbor integer pixel upscaler
//
// Input channel in_valid/in_ready/in_data: cmd 0 loads a source pixel,
// cmd 1 replays the next stored column of the current row. Each good item
// gives scale_x results on out_valid/out_ready/out_data; an item of the
// wrong kind gives a single rejected result and leaves the state alone.
// Configuration: cfg_we with cfg_addr and cfg_wdata, written while idle;
// zero acts as one, too-large values saturate.
// The first result of an item passes the front stage register, the queue,
// the current-item register and the output register. The output register
// emits one copy per cycle while the receiver takes them, so an item gives
// scale_x copies (one if rejected), counted by the replication counter in
// the back end. A four-entry queue separates the classifying front end from
// the back end, so items are taken while earlier copies still drain.
// Reset clears the position counters, queue and output valid; the line
// store holds no defined data until rows are loaded. When the receiver
// stalls, the output holds, the queue fills and in_ready then drops.
module integer_pixel_replicating_upscaler_top import ipru_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ipru_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ipru_out_t         out_data,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  logic [SCALE_W-1:0] scale_x_r, scale_y_r;
  logic [SIZE_W-1:0]  row_width_r, rect_height_r;
  ipru_cfg_t          cfg;

  logic        q_push, q_ready, q_pop, q_valid;
  ipru_entry_t push_entry, pop_entry;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r     <= SCALE_W'(1);
      scale_y_r     <= SCALE_W'(1);
      row_width_r   <= SIZE_W'(1);
      rect_height_r <= SIZE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SCALE_X:     scale_x_r     <= cfg_wdata[SCALE_W-1:0];
        REG_SCALE_Y:     scale_y_r     <= cfg_wdata[SCALE_W-1:0];
        REG_ROW_WIDTH:   row_width_r   <= cfg_wdata[SIZE_W-1:0];
        REG_RECT_HEIGHT: rect_height_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to the supported ranges
  always_comb begin
    if (scale_x_r == '0) cfg.scale_x = SCALE_W'(1);
    else if (scale_x_r > SCALE_W'(MAX_SCALE)) cfg.scale_x = SCALE_W'(MAX_SCALE);
    else cfg.scale_x = scale_x_r;

    if (scale_y_r == '0) cfg.scale_y = SCALE_W'(1);
    else if (scale_y_r > SCALE_W'(MAX_SCALE)) cfg.scale_y = SCALE_W'(MAX_SCALE);
    else cfg.scale_y = scale_y_r;

    if (row_width_r == '0) cfg.row_width = SIZE_W'(1);
    else if (row_width_r > SIZE_W'(MAX_ROW_WIDTH)) cfg.row_width = SIZE_W'(MAX_ROW_WIDTH);
    else cfg.row_width = row_width_r;

    if (rect_height_r == '0) cfg.rect_height = SIZE_W'(1);
    else if (rect_height_r > SIZE_W'(MAX_RECT_HEIGHT)) begin
      cfg.rect_height = SIZE_W'(MAX_RECT_HEIGHT);
    end else cfg.rect_height = rect_height_r;
  end

  ipru_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_ready  (q_ready),
    .q_entry  (push_entry)
  );

  ipru_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (pop_entry)
  );

  ipru_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sv/ipru_checker.sv @@
// port-level checks of the upscaler and their binding to the top level
`include "integer_pixel_replicating_upscaler_top_assert.svh"

module ipru_checker import ipru_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input ipru_out_t out_data
);

  logic stalled, rej_seen, rej_ok, end_seen, end_ok;

  // conditions the checks look at
  assign stalled  = out_valid && !out_ready;
  assign rej_seen = out_valid && out_data.rejected;
  assign rej_ok   = out_data.last_of_run && out_data.pixel_out == '0 &&
                    !out_data.end_of_line && !out_data.end_of_rect;
  assign end_seen = out_valid && (out_data.end_of_line || out_data.end_of_rect);
  assign end_ok   = out_data.last_of_run && (out_data.end_of_line || !out_data.end_of_rect);

  // a stalled result holds
  `IPRU_ASSERT(a_out_hold, stalled |=> out_valid && $stable(out_data), "stalled result changed")

  // a rejected result is a lone, empty copy
  `IPRU_ASSERT(a_reject_shape, rej_seen |-> rej_ok, "malformed rejected result")

  // line and rectangle ends fall on the last copy, rectangle end on a line end
  `IPRU_ASSERT(a_marker_order, end_seen |-> end_ok, "end marker off the last copy")

  // nothing is offered right after reset
  `IPRU_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "result offered after reset")

endmodule

bind integer_pixel_replicating_upscaler_top ipru_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
